FILE: rtl/mvti_pkg.sv
// Package for the material velocity time interpolator.
// Holds sizes, operation and status codes, and the sequencer state type.
// No dependencies.
package mvti_pkg;

   localparam int MATERIALS = 8;
   localparam int POINTS    = 64;
   localparam int MAT_W     = 3;
   localparam int PT_W      = $clog2(POINTS);
   localparam int CNT_W     = $clog2(POINTS + 1);
   localparam int ADDR_W    = $clog2(MATERIALS * POINTS);
   localparam int SEL_W     = (MATERIALS > 1) ? $clog2(MATERIALS) : 1;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_SPARE  = 2'd3;

   localparam logic [2:0] ST_PRESCRIBED   = 3'd0;
   localparam logic [2:0] ST_UNPRESCRIBED = 3'd1;
   localparam logic [2:0] ST_APPENDED     = 3'd2;
   localparam logic [2:0] ST_REJECTED     = 3'd3;
   localparam logic [2:0] ST_CLEARED      = 3'd4;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_RDLAST = 11'b00000000010,
      S_CHKAPP = 11'b00000000100,
      S_RDEND  = 11'b00000001000,
      S_CHKEND = 11'b00000010000,
      S_SRCH   = 11'b00000100000,
      S_SRCHW  = 11'b00001000000,
      S_RDA    = 11'b00010000000,
      S_DIV    = 11'b00100000000,
      S_MUL    = 11'b01000000000,
      S_OUT    = 11'b10000000000
   } state_type;

endpackage

FILE: rtl/material_velocity_time_interpolator.sv
// Top level of the material velocity time interpolator.
// Depends on mvti_pkg; holds the point stores, sequencer, shared divider and multiplier.
//
//  channel | ports                        | direction | handshake
//  req     | req_operation .. point_vel_z | in        | req_valid / req_stall
//  rsp     | rsp_status, rsp_out_vel_*    | out       | rsp_valid / rsp_stall
//  csr     | csr_data                     | in        | csr_valid / csr_ready
//
// Clear and spare codes go straight to the result; an append reads the last
// point and checks it; a query at or past the ends takes that end point; an
// interior query runs a binary search, then the bit-serial divider that forms
// the 16-bit weight, then six passes of the shared 33x32 multiplier.
// Synchronous reset clears point counts, sequencer and current time; stores
// are not cleared. req_stall is high while a request is in work; a finished
// result waits in S_OUT while the output register still holds one under rsp_stall.
module material_velocity_time_interpolator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_operation,
   input  logic [2:0]           req_material_id,
   input  logic signed [31:0]   req_point_time,
   input  logic signed [31:0]   req_point_vel_x,
   input  logic signed [31:0]   req_point_vel_y,
   input  logic signed [31:0]   req_point_vel_z,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic signed [31:0]   rsp_out_vel_x,
   output logic signed [31:0]   rsp_out_vel_y,
   output logic signed [31:0]   rsp_out_vel_z,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic signed [31:0]   csr_data
);
   import mvti_pkg::*;

   // point stores
   logic signed [31:0] time_mem [MATERIALS*POINTS];
   logic signed [31:0] vx_mem   [MATERIALS*POINTS];
   logic signed [31:0] vy_mem   [MATERIALS*POINTS];
   logic signed [31:0] vz_mem   [MATERIALS*POINTS];
   logic signed [31:0] rd_t, rd_x, rd_y, rd_z;
   logic signed [31:0] time_mem_first, fx, fy, fz;
   logic [ADDR_W-1:0]  rd_addr;
   logic               wr_en;

   logic [CNT_W-1:0]   count_ff [MATERIALS];
   state_type          state_ff, state_in;
   logic signed [31:0] cur_time_ff;
   logic [SEL_W-1:0]   mat_ff;
   logic signed [31:0] pt_ff, px_ff, py_ff, pz_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [CNT_W-1:0]   lo_ff, hi_ff;
   logic signed [31:0] tb_ff;
   logic signed [31:0] bx_ff, by_ff, bz_ff, ax_ff, ay_ff, az_ff;
   logic [32:0]        rem_ff, den_ff;
   logic [15:0]        wa_ff;
   logic [4:0]         step_ff;
   logic signed [65:0] acc_ff;
   logic               rv_ff;
   logic [2:0]         st_ff;
   logic signed [31:0] ox_ff, oy_ff, oz_ff;
   logic [2:0]         rsp_st_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;

   logic [PT_W-1:0]    mid;
   logic [CNT_W-1:0]   mid_w;
   logic [ADDR_W-1:0]  base;
   logic               req_acc;
   logic               req_mat_ok;
   logic               out_load;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign req_mat_ok = int'(req_material_id) < MATERIALS;
   assign out_load  = (state_ff == S_OUT) && (!rv_ff || !rsp_stall);
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_status = rsp_st_ff;
   assign rsp_out_vel_x = rsp_x_ff;
   assign rsp_out_vel_y = rsp_y_ff;
   assign rsp_out_vel_z = rsp_z_ff;

   assign base  = ADDR_W'(mat_ff) * ADDR_W'(POINTS);
   assign mid_w = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign mid   = mid_w[PT_W-1:0];

   // pick the store read address for the state
   always_comb begin
      rd_addr = base;
      case (state_ff)
         S_RDLAST, S_RDEND: rd_addr = base + ADDR_W'(n_ff - 1'b1);
         S_SRCH:            rd_addr = base + ADDR_W'(mid);
         S_RDA:             rd_addr = base + ADDR_W'(lo_ff - 1'b1);
         default:           rd_addr = base;
      endcase
   end

   assign wr_en = (state_ff == S_CHKAPP) && (n_ff < CNT_W'(POINTS)) &&
                  ((n_ff == '0) || (rd_t < pt_ff));

   // store ports: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[base + ADDR_W'(n_ff)] <= pt_ff;
         vx_mem[base + ADDR_W'(n_ff)]   <= px_ff;
         vy_mem[base + ADDR_W'(n_ff)]   <= py_ff;
         vz_mem[base + ADDR_W'(n_ff)]   <= pz_ff;
      end
      rd_t <= time_mem[rd_addr];
      rd_x <= vx_mem[rd_addr];
      rd_y <= vy_mem[rd_addr];
      rd_z <= vz_mem[rd_addr];
   end

   // shared multiplier operands: step selects component and weight
   logic signed [32:0] mw;
   logic signed [31:0] mv;
   logic signed [65:0] prod;
   always_comb begin
      case (step_ff[2:0])
         3'd0: begin mw = {17'd0, wa_ff}; mv = ax_ff; end
         3'd1: begin mw = 33'sd65536 - {17'd0, wa_ff}; mv = bx_ff; end
         3'd2: begin mw = {17'd0, wa_ff}; mv = ay_ff; end
         3'd3: begin mw = 33'sd65536 - {17'd0, wa_ff}; mv = by_ff; end
         3'd4: begin mw = {17'd0, wa_ff}; mv = az_ff; end
         default: begin mw = 33'sd65536 - {17'd0, wa_ff}; mv = bz_ff; end
      endcase
      prod = 66'(mw * mv);
   end

   logic [32:0] rem_sh;
   assign rem_sh = {rem_ff[31:0], 1'b0};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_acc) begin
            if (req_operation == OP_APPEND && req_mat_ok)
               state_in = S_RDLAST;
            else if (req_operation == OP_QUERY && req_mat_ok
                     && count_ff[SEL_W'(req_material_id)] != '0)
               state_in = S_RDEND;
            else
               state_in = S_OUT;
         end
         S_RDLAST: state_in = S_CHKAPP;
         S_CHKAPP: state_in = S_OUT;
         S_RDEND:  state_in = S_CHKEND;
         S_CHKEND: begin
            if (n_ff == CNT_W'(1) || cur_time_ff <= time_mem_first || cur_time_ff >= rd_t)
               state_in = S_OUT;
            else
               state_in = S_SRCH;
         end
         S_SRCH:   state_in = (lo_ff >= hi_ff) ? S_RDA : S_SRCHW;
         S_SRCHW:  state_in = S_SRCH;
         S_RDA:    state_in = S_DIV;
         S_DIV:    if (step_ff == 5'd16) state_in = S_MUL;
         S_MUL:    if (step_ff == 5'd5) state_in = S_OUT;
         S_OUT:    if (out_load) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // sequencer datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rv_ff       <= 1'b0;
         cur_time_ff <= '0;
         for (int i = 0; i < MATERIALS; i++) count_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) cur_time_ff <= csr_data;
         // hand the finished result to the output register, or drop a taken one
         if (out_load) begin
            rv_ff     <= 1'b1;
            rsp_st_ff <= st_ff;
            rsp_x_ff  <= ox_ff;
            rsp_y_ff  <= oy_ff;
            rsp_z_ff  <= oz_ff;
         end else if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_acc) begin
               mat_ff    <= SEL_W'(req_material_id);
               n_ff      <= count_ff[SEL_W'(req_material_id)];
               pt_ff <= req_point_time;
               px_ff <= req_point_vel_x;
               py_ff <= req_point_vel_y;
               pz_ff <= req_point_vel_z;
               ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
               if (req_operation == OP_APPEND) st_ff <= ST_REJECTED;
               else if (req_operation == OP_CLEAR) begin
                  st_ff <= ST_CLEARED;
                  if (req_mat_ok)
                     count_ff[SEL_W'(req_material_id)] <= '0;
               end else st_ff <= ST_UNPRESCRIBED;
            end
            S_CHKAPP: if (wr_en) begin
               st_ff <= ST_APPENDED;
               count_ff[mat_ff] <= n_ff + 1'b1;
            end
            S_CHKEND: begin
               // last point is on the read port
               st_ff <= ST_PRESCRIBED;
               tb_ff <= rd_t;
               if (n_ff == CNT_W'(1) || cur_time_ff <= time_mem_first) begin
                  ox_ff <= fx; oy_ff <= fy; oz_ff <= fz;
               end else if (cur_time_ff >= rd_t) begin
                  ox_ff <= rd_x; oy_ff <= rd_y; oz_ff <= rd_z;
               end else begin
                  lo_ff <= '0; hi_ff <= n_ff;
               end
            end
            S_SRCHW: begin
               if (rd_t < cur_time_ff) lo_ff <= mid_w + 1'b1;
               else hi_ff <= mid_w;
            end
            S_RDA: begin
               // b point is on the read port
               tb_ff <= rd_t; bx_ff <= rd_x; by_ff <= rd_y; bz_ff <= rd_z;
               step_ff <= '0;
               wa_ff <= '0;
            end
            S_DIV: begin
               if (step_ff == '0) begin
                  ax_ff <= rd_x; ay_ff <= rd_y; az_ff <= rd_z;
                  rem_ff <= 33'(33'(tb_ff) - 33'(cur_time_ff));
                  den_ff <= 33'(33'(tb_ff) - 33'(rd_t));
                  step_ff <= step_ff + 1'b1;
               end else begin
                  // one quotient bit per cycle
                  if (rem_sh >= den_ff) begin
                     rem_ff <= rem_sh - den_ff;
                     wa_ff  <= {wa_ff[14:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     wa_ff  <= {wa_ff[14:0], 1'b0};
                  end
                  if (step_ff == 5'd16) begin
                     step_ff <= '0; acc_ff <= '0;
                  end else step_ff <= step_ff + 1'b1;
               end
            end
            S_MUL: begin
               if (!step_ff[0]) acc_ff <= prod;
               else begin
                  case (step_ff[2:1])
                     2'd0:    ox_ff <= 32'((acc_ff + prod) >>> 16);
                     2'd1:    oy_ff <= 32'((acc_ff + prod) >>> 16);
                     default: oz_ff <= 32'((acc_ff + prod) >>> 16);
                  endcase
               end
               step_ff <= step_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // first point of the table, read in RDEND via a second registered port
   always_ff @(posedge clock) begin
      time_mem_first <= time_mem[base];
      fx <= vx_mem[base];
      fy <= vy_mem[base];
      fz <= vz_mem[base];
   end

endmodule
